>>> rtl/core/sfs_pkg.sv
// Package for the sprite frame sequencer: widths, codes and shared types.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package sfs_pkg;

  // Table depth and derived widths
  localparam int MAX_FRAMES = 16;
  localparam int IDX_W      = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int DUR_W      = 32;
  localparam int ELAPSED_W  = 16;
  localparam int OP_W       = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int FCOUNT_W   = 5;
  localparam int DIR_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_MODE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSED         = 2'd3;

  // Direction modes
  localparam logic [DIR_W-1:0] DIR_FORWARD  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_BACKWARD = 2'd1;
  localparam logic [DIR_W-1:0] DIR_PINGPONG = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef struct packed {
    logic [FCOUNT_W-1:0] frame_count;
    logic                loop_enable;
    logic [DIR_W-1:0]    direction_mode;
    logic                paused;
  } cfg_t;

  typedef struct packed {
    logic [DUR_W-1:0] time_acc;
    logic [IDX_W-1:0] frame;
    logic             forward;
    logic             finished;
    logic             pingpong;
  } seq_t;

  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [ELAPSED_W-1:0] elapsed;
    logic [IDX_W-1:0]     entry_index;
    logic [DUR_W-1:0]     entry_value;
  } item_t;

endpackage

>>> rtl/core/sfs_in_if.sv
// Input channel of the sprite frame sequencer: valid/ready plus item fields.
// Depends on sfs_pkg.
`timescale 1ns / 1ps

interface sfs_in_if;
  import sfs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [ELAPSED_W-1:0] elapsed;
  logic [IDX_W-1:0]     entry_index;
  logic [DUR_W-1:0]     entry_value;

  modport source (output valid, operation, elapsed, entry_index, entry_value, input ready);
  modport sink   (input valid, operation, elapsed, entry_index, entry_value, output ready);
endinterface

>>> rtl/core/sfs_out_if.sv
// Result channel of the sprite frame sequencer: valid/ready plus result fields.
// Depends on sfs_pkg.
`timescale 1ns / 1ps

interface sfs_out_if;
  import sfs_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] current_frame;
  logic             done_res;
  logic             going_backward;

  modport source (output valid, current_frame, done_res, going_backward, input ready);
  modport sink   (input valid, current_frame, done_res, going_backward, output ready);
endinterface

>>> rtl/core/sprite_frame_sequencer.sv
// Top level of the sprite frame sequencer: input register, sequence state,
// duration table, configuration registers and result register.
// Depends on sfs_pkg, sfs_in_if, sfs_out_if, sfs_dur_table and sfs_step.
//
// Usage:
//   in_i carries items: a tick (adds elapsed time, may step the frame), a
//   duration table write, or a restart from the configured direction mode.
//   Every item gives exactly one result on out_o: the frame index, the
//   finished flag and the backward flag as they stand after that item.
//   Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
//   by the user only while no item is in flight; the block does not enforce
//   it. They take effect for the next item. An item transferred on in_i is
//   held in the input register, then processed into the result register and
//   offered on out_o from then on. Throughput is one item per cycle while out_o
//   is not stalled; the state update (one 32-bit add, one 32-bit compare, a
//   16-entry table read) is combinational, so items may follow back to back.
//   When the receiver stalls, the result register holds and the input
//   register takes one more item, then in_i.ready drops.
//   Reset clears the duration table, the sequence state (frame 0, forward,
//   not finished) and the registers to frame count 1, all others zero.
`timescale 1ns / 1ps

module sprite_frame_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  sfs_in_if.sink                        in_i,
  sfs_out_if.source                     out_o
);
  import sfs_pkg::*;

  cfg_t             cfg_q;
  seq_t             seq_q, seq_d;
  item_t            item_q;
  logic             item_valid_q;
  logic             out_valid_q;
  logic [IDX_W-1:0] res_frame_q;
  logic             res_done_q;
  logic             res_back_q;
  logic             advance;
  logic             process;
  logic             in_xfer;
  logic             table_we;
  logic [DUR_W-1:0] dur;

  // Handshake control
  assign advance   = !out_valid_q || out_o.ready;
  assign process   = item_valid_q && advance;
  assign in_i.ready = !item_valid_q || advance;
  assign in_xfer   = in_i.valid && in_i.ready;
  assign table_we  = process && (op_e'(item_q.operation) == OP_WRITE);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_count    <= FCOUNT_W'(1);
      cfg_q.loop_enable    <= 1'b0;
      cfg_q.direction_mode <= DIR_FORWARD;
      cfg_q.paused         <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_COUNT:    cfg_q.frame_count    <= cfg_wdata_i[FCOUNT_W-1:0];
        REG_LOOP_ENABLE:    cfg_q.loop_enable    <= cfg_wdata_i[0];
        REG_DIRECTION_MODE: cfg_q.direction_mode <= cfg_wdata_i[DIR_W-1:0];
        REG_PAUSED:         cfg_q.paused         <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Input register: load on transfer, drain when processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_xfer) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.operation   <= in_i.operation;
      item_q.elapsed     <= in_i.elapsed;
      item_q.entry_index <= in_i.entry_index;
      item_q.entry_value <= in_i.entry_value;
    end
  end

  sfs_dur_table u_dur_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (table_we),
    .waddr_i (item_q.entry_index),
    .wdata_i (item_q.entry_value),
    .raddr_i (seq_q.frame),
    .rdata_o (dur)
  );

  sfs_step u_step (
    .cfg_i  (cfg_q),
    .cur_i  (seq_q),
    .item_i (item_q),
    .dur_i  (dur),
    .nxt_o  (seq_d)
  );

  // Sequence state: advance once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q.time_acc <= '0;
      seq_q.frame    <= '0;
      seq_q.forward  <= 1'b1;
      seq_q.finished <= 1'b0;
      seq_q.pingpong <= 1'b0;
    end else if (process) begin
      seq_q <= seq_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (process) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      res_frame_q <= seq_d.frame;
      res_done_q  <= seq_d.finished;
      res_back_q  <= !seq_d.forward;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.current_frame  = res_frame_q;
  assign out_o.done_res       = res_done_q;
  assign out_o.going_backward = res_back_q;

  // Restart lands on frame 0, not finished, with time cleared
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && (op_e'(item_q.operation) == OP_RESTART)
    |=> seq_q.frame == '0 && !seq_q.finished && seq_q.time_acc == '0)
    else $error("restart did not return to frame 0");

  // A paused tick changes no state
  a_paused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && (op_e'(item_q.operation) == OP_TICK) && cfg_q.paused
    |=> $stable(seq_q))
    else $error("paused tick changed the sequence state");

  // The result reports the state left by the item
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process |=> out_valid_q && res_frame_q == seq_q.frame
                && res_done_q == seq_q.finished && res_back_q == !seq_q.forward)
    else $error("result does not match sequence state");

  // A write leaves the sequence state untouched
  a_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    table_we |=> $stable(seq_q))
    else $error("table write changed the sequence state");

endmodule

>>> rtl/core/sfs_dur_table.sv
// Frame duration table: one write port, one combinational read port.
// Entries are flops cleared at reset. Depends on sfs_pkg.
`timescale 1ns / 1ps

module sfs_dur_table (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [sfs_pkg::IDX_W-1:0] waddr_i,
  input  logic [sfs_pkg::DUR_W-1:0] wdata_i,
  input  logic [sfs_pkg::IDX_W-1:0] raddr_i,
  output logic [sfs_pkg::DUR_W-1:0] rdata_o
);
  import sfs_pkg::*;

  logic [DUR_W-1:0] dur_q [MAX_FRAMES];

  // Store one entry per write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        dur_q[i] <= '0;
      end
    end else if (we_i) begin
      dur_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = dur_q[raddr_i];

endmodule

>>> rtl/core/sfs_step.sv
// Next-state logic of the sprite frame sequencer for one item: saturating
// time accumulate, duration compare and frame stepping rules. Depends on sfs_pkg.
`timescale 1ns / 1ps

module sfs_step (
  input  sfs_pkg::cfg_t             cfg_i,
  input  sfs_pkg::seq_t             cur_i,
  input  sfs_pkg::item_t            item_i,
  input  logic [sfs_pkg::DUR_W-1:0] dur_i,
  output sfs_pkg::seq_t             nxt_o
);
  import sfs_pkg::*;

  logic [DUR_W:0]   sum;
  logic [DUR_W-1:0] acc_sat;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] frame_inc;
  logic [IDX_W-1:0] last_idx;

  // Clamp the frame count into 1..MAX_FRAMES
  always_comb begin
    if (cfg_i.frame_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (CNT_W'(cfg_i.frame_count) > CNT_W'(MAX_FRAMES)) begin
      n_eff = CNT_W'(MAX_FRAMES);
    end else begin
      n_eff = CNT_W'(cfg_i.frame_count);
    end
  end

  assign last_idx  = IDX_W'(n_eff - 1'b1);
  assign frame_inc = CNT_W'({1'b0, cur_i.frame}) + 1'b1;
  assign sum       = {1'b0, cur_i.time_acc} + (DUR_W+1)'(item_i.elapsed);
  assign acc_sat   = sum[DUR_W] ? '1 : sum[DUR_W-1:0];

  // Apply the item to the sequence state
  always_comb begin
    nxt_o = cur_i;
    case (op_e'(item_i.operation))
      OP_TICK: begin
        if (!cfg_i.paused) begin
          nxt_o.time_acc = acc_sat;
          nxt_o.finished = 1'b0;
          if (acc_sat > dur_i) begin
            if (cur_i.forward) begin
              if (frame_inc >= n_eff) begin
                if (cur_i.pingpong) begin
                  // turn around at the last frame
                  nxt_o.forward = 1'b0;
                  nxt_o.frame   = (cur_i.frame != '0) ? cur_i.frame - 1'b1 : '0;
                end else begin
                  if (cfg_i.loop_enable) begin
                    nxt_o.frame = '0;
                  end
                  nxt_o.finished = 1'b1;
                end
              end else begin
                nxt_o.frame = cur_i.frame + 1'b1;
              end
            end else begin
              if (cur_i.frame == '0) begin
                nxt_o.finished = 1'b1;
                if (cur_i.pingpong) begin
                  if (cfg_i.loop_enable) begin
                    nxt_o.forward = 1'b1;
                    nxt_o.frame   = (n_eff == CNT_W'(1)) ? '0 : IDX_W'(1);
                  end
                end else if (cfg_i.loop_enable) begin
                  nxt_o.frame = last_idx;
                end
              end else begin
                nxt_o.frame = cur_i.frame - 1'b1;
              end
            end
            // clear time after a step only when looping and not finished
            if (cfg_i.loop_enable && !nxt_o.finished) begin
              nxt_o.time_acc = '0;
            end
          end
        end
      end
      OP_RESTART: begin
        nxt_o.time_acc = '0;
        nxt_o.frame    = '0;
        nxt_o.finished = 1'b0;
        nxt_o.forward  = (cfg_i.direction_mode != DIR_BACKWARD);
        nxt_o.pingpong = (cfg_i.direction_mode == DIR_PINGPONG);
      end
      default: begin
        // writes and unused codes leave the sequence alone
      end
    endcase
  end

endmodule
